@@ hw/rtl/countdown_timer_decimal_display_top_macros.svh @@
// assertion macros for the countdown timer display block
`ifndef COUNTDOWN_TIMER_DECIMAL_DISPLAY_TOP_MACROS_SVH
`define COUNTDOWN_TIMER_DECIMAL_DISPLAY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define CTDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define CTDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTDD_ASSERT_NOW(lbl, ante, cons, msg)
`define CTDD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/ctdd_pkg.sv @@
package ctdd_pkg;

  // field widths
  localparam int TIME_W     = 24;
  localparam int COUNT_W    = 16;
  localparam int OUT_PLACES = 6;
  localparam int DIGIT_W    = 4;

  // default number of decimal places kept
  localparam int NUM_DIGITS_DEF = 6;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ZEROS  = 2'd1;

  // input kind codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // output beat layout
  localparam int OUT_DATA_W = 56;

endpackage

@@ hw/rtl/countdown_timer_decimal_display_top.sv @@
// A load, or a tick whose prescale count matches the period, passes through the
// shift-and-add-3 decimal converter, one bit per cycle over all TIME_W bits, and then waits
// for the output register; any other tick skips the converter and goes straight to the wait.
// The converter handles one item at a time: no new beat is taken until the output is loaded.
// Reset (rst_n, synchronous, active low): time, prescale count and digits to zero,
// tick_period to 0, show_leading_zeros to 1, output channel empty.
`include "countdown_timer_decimal_display_top_macros.svh"

module countdown_timer_decimal_display_top
  import ctdd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TIME_W-1:0]     in_tdata,   // [23:0] load_value
  input  logic                  in_tuser,   // [0] action
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [23:0] remaining, [47:24] digits,
                                            // [53:48] visible_mask, [55:54] zero
  output logic                  out_tuser,  // [0] stepped
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BCD_W  = NUM_DIGITS * DIGIT_W;
  localparam int PAD_P  = (NUM_DIGITS > OUT_PLACES) ? NUM_DIGITS : OUT_PLACES;
  localparam int ITER_W = $clog2(TIME_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [BCD_W-1:0]   digit_r, digit_nxt;
  logic [TIME_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic               step_r, step_nxt;
  logic [COUNT_W-1:0] period_r;
  logic               show_r;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_user_r;

  logic               in_acc;
  logic               out_load;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   bcd_shift;
  logic [PAD_P*DIGIT_W-1:0] dig_pad;
  logic [PAD_P-1:0]   vis_pad;
  logic [NUM_DIGITS-1:0] vis_all;
  logic               shown;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      show_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TICK_PERIOD: period_r <= cfg_data;
        REG_SHOW_ZEROS:  show_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // add-3 correction on every digit, then shift in the next binary bit
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign bcd_shift = {bcd_adj[BCD_W-2:0], bin_r[TIME_W-1]};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    time_nxt  = time_r;
    count_nxt = count_r;
    digit_nxt = digit_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    iter_nxt  = iter_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_LOAD) begin
            time_nxt  = in_tdata;
            count_nxt = '0;
            step_nxt  = 1'b1;
          end else if (count_r == period_r) begin
            time_nxt  = (time_r != '0) ? time_r - 1'b1 : time_r;
            count_nxt = COUNT_W'(1);
            step_nxt  = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
            step_nxt  = 1'b0;
          end
          bin_nxt   = time_nxt;
          bcd_nxt   = '0;
          iter_nxt  = '0;
          state_nxt = step_nxt ? ST_CONV : ST_FIN;
        end
      end
      ST_CONV: begin
        bcd_nxt  = bcd_shift;
        bin_nxt  = {bin_r[TIME_W-2:0], 1'b0};
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(TIME_W - 1)) begin
          digit_nxt = bcd_shift;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      time_r  <= '0;
      count_r <= '0;
      digit_r <= '0;
    end else begin
      state_r <= state_nxt;
      time_r  <= time_nxt;
      count_r <= count_nxt;
      digit_r <= digit_nxt;
    end
  end

  // converter working registers
  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    iter_r <= iter_nxt;
    step_r <= step_nxt;
  end

  // blanking scan from the most significant place down
  always_comb begin
    shown = show_r;
    for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
      if (digit_r[p*DIGIT_W +: DIGIT_W] != '0 || p == 0) begin
        shown = 1'b1;
      end
      vis_all[p] = shown;
    end
  end

  assign dig_pad = (PAD_P*DIGIT_W)'(digit_r);
  assign vis_pad = PAD_P'(vis_all);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {2'b00, vis_pad[OUT_PLACES-1:0],
                     dig_pad[OUT_PLACES*DIGIT_W-1:0], time_r};
      out_user_r <= step_r;
    end
  end

  // checks
  `CTDD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "input taken while an item is still in work")
  `CTDD_ASSERT_NOW(a_iter_bound, state_r == ST_CONV, iter_r <= ITER_W'(TIME_W - 1),
    "converter ran past its last bit")
  `CTDD_ASSERT_NEXT(a_hold_result, state_r == ST_FIN && out_valid_r && !out_tready,
    state_r == ST_FIN, "result dropped while the output beat is stalled")
  `CTDD_ASSERT_NEXT(a_saturate, in_tvalid && in_tready && in_tuser == ACT_TICK &&
    time_r == '0, time_r == '0, "remaining time went below zero")

endmodule

@@ tb/countdown_timer_decimal_display_top_test.sv @@
module countdown_timer_decimal_display_top_test;
  import ctdd_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int PLACES      = NUM_DIGITS_DEF;
  localparam int RADIX       = 10;
  localparam int DIG_LO      = TIME_W;
  localparam int VIS_LO      = TIME_W + OUT_PLACES * DIGIT_W;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  // one expected readout of the display
  typedef struct packed {
    logic [TIME_W-1:0]             remaining;
    logic [OUT_PLACES*DIGIT_W-1:0] digits;
    logic [OUT_PLACES-1:0]         visible;
    logic                          stepped;
  } readout_t;

  // timer predictor plus queue of pending readouts
  class countdown_board;
    logic [COUNT_W-1:0] period;
    logic               show_zeros;
    logic [TIME_W-1:0]  time_left;
    logic [COUNT_W-1:0] count;
    logic [DIGIT_W-1:0] store [PLACES];
    readout_t           pending_readouts [$];
    int                 errors;

    function new();
      period     = '0;
      show_zeros = 1'b1;
      time_left  = '0;
      count      = '0;
      foreach (store[p]) store[p] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TICK_PERIOD) period = val[COUNT_W-1:0];
      else if (idx == REG_SHOW_ZEROS) show_zeros = val[0];
    endfunction

    // time modulo 10^places, one decimal digit per place
    function void refresh_store();
      int unsigned v;
      v = 32'(time_left);
      foreach (store[p]) begin
        store[p] = DIGIT_W'(v % RADIX);
        v = v / RADIX;
      end
    endfunction

    function void note_item(logic act, logic [TIME_W-1:0] val);
      readout_t r;
      bit       lit;
      r = '0;
      if (act == ACT_LOAD) begin
        time_left = val;
        count     = '0;
        refresh_store();
        r.stepped = 1'b1;
      end else if (count == period) begin
        // saturating decrement, display refreshed even at zero
        if (time_left != '0) time_left = time_left - 1'b1;
        refresh_store();
        count     = COUNT_W'(1);
        r.stepped = 1'b1;
      end else begin
        count = count + 1'b1;
      end
      // blanking scans from the top place down, place 0 always lit
      lit = show_zeros;
      for (int p = PLACES - 1; p >= 0; p--) begin
        if (store[p] != '0 || p == 0) lit = 1'b1;
        if (p < OUT_PLACES) begin
          r.digits[DIGIT_W*p +: DIGIT_W] = store[p];
          if (lit) r.visible[p] = 1'b1;
        end
      end
      r.remaining = time_left;
      pending_readouts.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data, logic user);
      readout_t want;
      if (pending_readouts.size() == 0) begin
        $display("%0t: result beat with nothing pending, tdata %h tuser %b",
                 $time, data, user);
        errors++;
      end else begin
        want = pending_readouts.pop_front();
        compare_field("remaining", want.remaining, data[TIME_W-1:0]);
        compare_field("digits", want.digits, data[DIG_LO +: OUT_PLACES*DIGIT_W]);
        compare_field("visible_mask", want.visible, data[VIS_LO +: OUT_PLACES]);
        compare_field("stepped", want.stepped, user);
      end
    endfunction

    function void flush_check();
      if (pending_readouts.size() != 0) begin
        $display("%0t: %0d readouts never arrived", $time, pending_readouts.size());
        errors += pending_readouts.size();
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TIME_W-1:0]     in_tdata;   // [23:0] load_value
  logic                  in_tuser;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [23:0] remaining, [47:24] digits,
                                     // [53:48] visible_mask, [55:54] zero
  logic                  out_tuser;  // [0] stepped
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  countdown_board board;
  bit             idle_off = 1'b0;

  countdown_timer_decimal_display_top #(
    .NUM_DIGITS(PLACES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // offer one beat, with random gaps ahead of it
  task automatic send_item(input logic act, input logic [TIME_W-1:0] val);
    while (!idle_off && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(act, val);
  endtask

  // stop offering and wait for every pending readout
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_readouts.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [COUNT_W-1:0] period, input logic zeros);
    write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, CFG_DATA_W'($urandom));
    write_reg(REG_TICK_PERIOD, period);
    // upper data bits are don't-care for the blanking flag
    write_reg(REG_SHOW_ZEROS, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | zeros);
    cfg_valid <= 1'b0;
  endtask

  // load values biased to small counts, digit rollovers and blank patterns
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] v;
    v = '0;
    case ($urandom_range(5))
      0: v = TIME_W'($urandom_range(12));
      1: v = TIME_W'($urandom_range(999));
      2: v = TIME_W'($urandom_range(1000010, 999990));
      3: for (int p = 0; p < OUT_PLACES; p++)
           v = TIME_W'(v * RADIX + ($urandom_range(1) ? 0 : $urandom_range(RADIX - 1)));
      4: v = TIME_W'({TIME_W{1'b1}} - $urandom_range(3));
      default: v = TIME_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic run_directed();
    // reset defaults: period zero matches at once, time already zero
    send_item(ACT_TICK, 24'h000000);
    send_item(ACT_TICK, 24'hFFFFFF);
    send_item(ACT_LOAD, 24'd0);
    send_item(ACT_TICK, 24'd0);
    send_item(ACT_LOAD, 24'd1);
    send_item(ACT_TICK, 24'h555555);
    send_item(ACT_LOAD, 24'hFFFFFF);
    send_item(ACT_LOAD, 24'd999999);
    send_item(ACT_TICK, 24'hAAAAAA);
    send_item(ACT_LOAD, 24'd1000000);
    send_item(ACT_LOAD, 24'd100500);
    drain();
    // blank leading zeros, decrement on every tick but the first after a load
    apply_settings(16'd1, 1'b0);
    send_item(ACT_LOAD, 24'd1000000);
    send_item(ACT_LOAD, 24'd100500);
    send_item(ACT_LOAD, 24'd7);
    send_item(ACT_TICK, 24'd0);
    send_item(ACT_TICK, 24'd0);
    send_item(ACT_TICK, 24'd0);
    send_item(ACT_LOAD, 24'h800000);
    send_item(ACT_LOAD, 24'd1234567);
    send_item(ACT_LOAD, 24'd10);
    send_item(ACT_TICK, 24'd0);
    send_item(ACT_TICK, 24'd0);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] period, input logic zeros,
                           input int n_items, input bit calm);
    drain();
    apply_settings(period, zeros);
    idle_off = calm;
    repeat (n_items) begin
      if ($urandom_range(99) < 15) send_item(ACT_LOAD, pick_time());
      else send_item(ACT_TICK, TIME_W'($urandom));
    end
    idle_off = 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TICK_PERIOD;
    cfg_data  <= '0;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(16'd1, 1'b0, 250, 1'b0);
    run_phase(16'd0, 1'b1, 250, 1'b0);
    run_phase(16'hFFFF, 1'b0, 250, 1'b0);
    run_phase(16'd2, 1'b1, 250, 1'b0);
    run_phase(16'd4, 1'b0, 250, 1'b1);
    run_phase(COUNT_W'($urandom_range(7)), 1'($urandom_range(1)), 250, 1'b0);
    run_phase(16'd3, 1'b1, 250, 1'b0);
    drain();
    repeat (40) @(posedge clk);
    board.flush_check();
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // result side: random backpressure plus one long hold-off
  initial begin
    int results_seen;
    int hold_left;
    bit hold_done;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
        board.check_beat(out_tdata, out_tuser);
        results_seen++;
      end
      if (!hold_done && results_seen >= 200) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(!idle_off && $urandom_range(99) < 7);
      end
    end
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ctdd_pkg.sv
hw/rtl/countdown_timer_decimal_display_top.sv
tb/countdown_timer_decimal_display_top_test.sv
